// ===== rtl/hsm_pkg.sv =====
// ----------------------------------------------------------------------------
// hsm_pkg
// Types, constants and corner tables for the stepped heightfield mesher.
// ----------------------------------------------------------------------------
`default_nettype none

package hsm_pkg;

  localparam int unsigned MAX_DIM  = 128;
  localparam int unsigned CRD_W    = 7;              // cell coordinate bits
  localparam int unsigned ADDR_W   = 2 * CRD_W;      // grid store address bits
  localparam int unsigned DIM_W    = 8;              // register / position bits
  localparam int unsigned HGT_W    = 16;
  localparam int unsigned TEX_W    = 16;
  localparam int unsigned IDX_W    = 19;
  localparam int unsigned IN_DW    = 32;
  localparam int unsigned OUT_DW   = 96;

  // register indexes
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_LENGTH = 1'b1;

  // item kinds
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_CELL = 1'b1;

  // wall codes, top face last
  localparam logic [2:0] WALL_NX  = 3'd0;
  localparam logic [2:0] WALL_PX  = 3'd1;
  localparam logic [2:0] WALL_NZ  = 3'd2;
  localparam logic [2:0] WALL_PZ  = 3'd3;
  localparam logic [2:0] WALL_TOP = 3'd4;

  localparam logic [1:0] NRM_POS  = 2'b01;
  localparam logic [1:0] NRM_NEG  = 2'b11;
  localparam logic [1:0] NRM_ZERO = 2'b00;

  // wall vertex at cell height (bit j for vertex j)
  localparam logic [5:0] AT_CELL = 6'b110100;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_EMIT
  } state_t;

  // x corner offsets, bit j for vertex j
  function automatic logic [5:0] offs_x(input logic [2:0] wall);
    logic [5:0] v;
    v = 6'b000000;
    unique case (wall)
      WALL_TOP: v = 6'b110100;
      WALL_NX:  v = 6'b000000;
      WALL_PX:  v = 6'b111111;
      WALL_NZ:  v = 6'b100101;
      WALL_PZ:  v = 6'b010110;
      default:  v = 6'b000000;
    endcase
    return v;
  endfunction

  // z corner offsets, bit j for vertex j
  function automatic logic [5:0] offs_z(input logic [2:0] wall);
    logic [5:0] v;
    v = 6'b000000;
    unique case (wall)
      WALL_TOP: v = 6'b010110;
      WALL_NX:  v = 6'b010110;
      WALL_PX:  v = 6'b100101;
      WALL_NZ:  v = 6'b000000;
      WALL_PZ:  v = 6'b111111;
      default:  v = 6'b000000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/heightfield_step_mesh.sv =====
// ----------------------------------------------------------------------------
// heightfield_step_mesh
// Stepped heightfield mesher: height store plus per-cell wall/top vertex
// generator.
// ----------------------------------------------------------------------------
//  channel | dir | tdata / tuser                               | other
//  in_     | in  | x, z, height / func                         | -
//  out_    | out | pos, normal, tex, index                     | tlast = last
//  cfg_    | in  | index 0 grid_width, 1 grid_length           | write only
//
//  a load beat is a single write into the grid memory
//  a cell beat first runs a setup phase (three reads on the memory port
//  overlap the 16-step bit-serial tex dividers), then one beat per vertex:
//  6 to 30 output beats, each stalled by out_tready
//  reset clears control state and the vertex counter; the store is not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module heightfield_step_mesh (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [hsm_pkg::IN_DW-1:0]  in_tdata,   // cell_x, cell_z, height
  input  wire logic                       in_tuser,   // func
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [hsm_pkg::OUT_DW-1:0]      out_tdata,  // pos_x, pos_y, pos_z,
                                                      // normal_x/y/z, tex_u,
                                                      // tex_v, vertex_index
  output logic                            out_tlast,
  input  wire logic                       cfg_we,
  input  wire logic                       cfg_addr,
  input  wire logic [hsm_pkg::DIM_W-1:0]  cfg_wdata
);

  localparam int unsigned CW = hsm_pkg::CRD_W;
  localparam int unsigned DW = hsm_pkg::DIM_W;
  localparam int unsigned HW = hsm_pkg::HGT_W;
  localparam int unsigned TW = hsm_pkg::TEX_W;
  localparam int unsigned IW = hsm_pkg::IDX_W;
  localparam int unsigned AW = hsm_pkg::ADDR_W;

  hsm_pkg::state_t state_r, state_nxt;

  logic [DW-1:0] gw_r, gl_r, w_eff, l_eff;
  logic [DW-1:0] w_r, l_r;
  logic [CW-1:0] x_r, z_r;
  logic [3:0]    cnt_r;
  logic signed [HW-1:0] y_r, nb1_r, nb3_r;
  logic [DW-1:0] rem_u_r, rem_v_r;
  logic [TW-1:0] tu_r, tv_r;
  logic [IW-1:0] count_r;
  logic [2:0]    wall_r, vtx_r;

  logic [HW-1:0] mem [hsm_pkg::MAX_DIM*hsm_pkg::MAX_DIM];
  logic [HW-1:0] rdata_r;
  logic [AW-1:0] rd_addr;
  logic          rd_en;

  logic          in_acc, out_acc;
  logic [CW-1:0] in_x, in_z;
  logic [HW-1:0] in_h;

  assign in_x = in_tdata[CW-1:0];
  assign in_z = in_tdata[2*CW-1:CW];
  assign in_h = in_tdata[2*CW+HW-1:2*CW];
  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  // register values clamped to 1..MAX_DIM
  always_comb begin
    w_eff = (gw_r == '0) ? DW'(1) : gw_r;
    if (gw_r > DW'(hsm_pkg::MAX_DIM)) w_eff = DW'(hsm_pkg::MAX_DIM);
    l_eff = (gl_r == '0) ? DW'(1) : gl_r;
    if (gl_r > DW'(hsm_pkg::MAX_DIM)) l_eff = DW'(hsm_pkg::MAX_DIM);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r <= DW'(hsm_pkg::MAX_DIM);
      gl_r <= DW'(hsm_pkg::MAX_DIM);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        hsm_pkg::REG_GRID_WIDTH:  gw_r <= cfg_wdata;
        hsm_pkg::REG_GRID_LENGTH: gl_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // grid memory
  always_comb begin
    unique case (cnt_r[1:0])
      2'd1:    rd_addr = {z_r, x_r + CW'(1)};
      2'd2:    rd_addr = {z_r + CW'(1), x_r};
      default: rd_addr = {z_r, x_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_tuser == hsm_pkg::FUNC_LOAD) begin
      mem[{in_z, in_x}] <= in_h;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // active walls
  logic [3:0] act;
  always_comb begin
    act[0] = (x_r == '0) && (y_r != '0);
    act[1] = nb1_r != y_r;
    act[2] = (z_r == '0) && (y_r != '0);
    act[3] = nb3_r != y_r;
  end

  function automatic logic [2:0] next_after(input logic [3:0] a, input logic [2:0] cur);
    logic [2:0] r;
    logic       found;
    r = hsm_pkg::WALL_TOP;
    found = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (!found && a[k] && (3'(k) > cur)) begin
        r = 3'(k);
        found = 1'b1;
      end
    end
    return r;
  endfunction

  logic       in_range;
  assign in_range = ({1'b0, in_x} < w_eff) && ({1'b0, in_z} < l_eff);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hsm_pkg::ST_IDLE:
        if (in_acc && in_tuser == hsm_pkg::FUNC_CELL && in_range) begin
          state_nxt = hsm_pkg::ST_CALC;
        end
      hsm_pkg::ST_CALC:
        if (cnt_r == 4'd15) state_nxt = hsm_pkg::ST_EMIT;
      hsm_pkg::ST_EMIT:
        if (out_acc && wall_r == hsm_pkg::WALL_TOP && vtx_r == 3'd5) begin
          state_nxt = hsm_pkg::ST_IDLE;
        end
      default: state_nxt = hsm_pkg::ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    rd_en      = 1'b0;
    unique case (state_r)
      hsm_pkg::ST_IDLE: in_tready = 1'b1;
      hsm_pkg::ST_CALC: rd_en = (cnt_r < 4'd3);
      hsm_pkg::ST_EMIT: out_tvalid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hsm_pkg::ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc && in_tuser == hsm_pkg::FUNC_CELL && in_range &&
          in_x == '0 && in_z == '0) begin
        count_r <= '0;
      end else if (out_acc) begin
        count_r <= count_r + IW'(1);
      end
    end
  end

  // datapath
  logic [DW:0] t_u, t_v;
  logic        ge_u, ge_v;
  assign t_u  = {rem_u_r, 1'b0};
  assign t_v  = {rem_v_r, 1'b0};
  assign ge_u = t_u >= {1'b0, w_r};
  assign ge_v = t_v >= {1'b0, l_r};

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r     <= in_x;
      z_r     <= in_z;
      w_r     <= w_eff;
      l_r     <= l_eff;
      cnt_r   <= '0;
      rem_u_r <= DW'(in_x);
      rem_v_r <= DW'(in_z);
      tu_r    <= '0;
      tv_r    <= '0;
    end else if (state_r == hsm_pkg::ST_CALC) begin
      cnt_r   <= cnt_r + 4'd1;
      // one quotient bit per cycle
      rem_u_r <= ge_u ? DW'(t_u - {1'b0, w_r}) : DW'(t_u);
      rem_v_r <= ge_v ? DW'(t_v - {1'b0, l_r}) : DW'(t_v);
      tu_r    <= {tu_r[TW-2:0], ge_u};
      tv_r    <= {tv_r[TW-2:0], ge_v};
      unique case (cnt_r)
        4'd1: y_r <= rdata_r;
        4'd2: nb1_r <= ({1'b0, x_r} == w_r - DW'(1)) ? '0 : rdata_r;
        4'd3: nb3_r <= ({1'b0, z_r} == l_r - DW'(1)) ? '0 : rdata_r;
        default: ;
      endcase
      if (cnt_r == 4'd15) begin
        wall_r <= act[0] ? hsm_pkg::WALL_NX : next_after(act, hsm_pkg::WALL_NX);
        vtx_r  <= '0;
      end
    end else if (state_r == hsm_pkg::ST_EMIT && out_acc) begin
      if (vtx_r == 3'd5) begin
        vtx_r  <= '0;
        wall_r <= next_after(act, wall_r);
      end else begin
        vtx_r <= vtx_r + 3'd1;
      end
    end
  end

  // vertex fields
  logic signed [HW-1:0] nbw, py;
  logic                 neg;
  logic [DW-1:0]        px, pz;
  logic [1:0]           nx, ny, nz;
  logic [5:0]           ox, oz;

  always_comb begin
    ox = hsm_pkg::offs_x(wall_r);
    oz = hsm_pkg::offs_z(wall_r);
    case (wall_r)
      hsm_pkg::WALL_PX:  nbw = nb1_r;
      hsm_pkg::WALL_PZ:  nbw = nb3_r;
      hsm_pkg::WALL_TOP: nbw = y_r;
      default:           nbw = '0;
    endcase
    neg = nbw < y_r;
    py  = hsm_pkg::AT_CELL[vtx_r] ? y_r : nbw;
    px  = DW'(x_r) + DW'(ox[vtx_r]);
    pz  = DW'(z_r) + DW'(oz[vtx_r]);
    nx  = hsm_pkg::NRM_ZERO;
    ny  = hsm_pkg::NRM_ZERO;
    nz  = hsm_pkg::NRM_ZERO;
    case (wall_r)
      hsm_pkg::WALL_NX: nx = neg ? hsm_pkg::NRM_NEG : hsm_pkg::NRM_POS;
      hsm_pkg::WALL_PX: nx = neg ? hsm_pkg::NRM_POS : hsm_pkg::NRM_NEG;
      hsm_pkg::WALL_NZ: nz = neg ? hsm_pkg::NRM_NEG : hsm_pkg::NRM_POS;
      hsm_pkg::WALL_PZ: nz = neg ? hsm_pkg::NRM_POS : hsm_pkg::NRM_NEG;
      default:          ny = hsm_pkg::NRM_POS;
    endcase
    out_tdata = {7'd0, count_r, tv_r, tu_r, nz, ny, nx, pz, py, px};
    out_tlast = (wall_r == hsm_pkg::WALL_TOP) && (vtx_r == 3'd5);
  end

endmodule

`default_nettype wire
